@@ rtl/core/imu_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Yaw frame parser package
// Shared constants and types for the frame collector and the heading unwrap.
// ----------------------------------------------------------------------------
package imu_pkg;

    localparam int unsigned POS_W = 5;

    localparam logic [7:0]       HDR_BYTE   = 8'hAA;
    localparam logic [POS_W-1:0] POS_SUM0   = POS_W'(2);
    localparam logic [POS_W-1:0] POS_YAW_LO = POS_W'(3);
    localparam logic [POS_W-1:0] POS_YAW_HI = POS_W'(4);
    localparam logic [POS_W-1:0] POS_CHECK  = POS_W'(18);

    localparam logic signed [16:0] HALF_TURN = 17'sd18000;
    localparam logic signed [16:0] FULL_TURN = 17'sd36000;
    localparam logic signed [15:0] REV_MAX   = 16'sd32767;
    localparam logic signed [15:0] REV_MIN   = -16'sd32767;

    // Completed frame, presented for one processed word.
    typedef struct packed {
        logic               done;
        logic               good;
        logic signed [15:0] yaw;
    } t_frame_evt;

endpackage
`default_nettype wire

@@ rtl/core/imu_frame.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Frame collector
// Hunts for the header pair, tracks the byte position and running checksum,
// and flags each completed frame with its checksum result and raw yaw.
// ----------------------------------------------------------------------------
module imu_frame
    import imu_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_en,
    input  wire logic [7:0] i_byte,
    output t_frame_evt      o_evt,
    output logic            o_at_check
);

    logic [POS_W-1:0] r_pos, n_pos;
    logic [7:0]       r_sum, n_sum;
    logic [7:0]       r_yaw_lo, n_yaw_lo;
    logic [7:0]       r_yaw_hi, n_yaw_hi;

    assign o_at_check = (r_pos == POS_CHECK);

    always_comb begin
        n_pos    = r_pos;
        n_sum    = r_sum;
        n_yaw_lo = r_yaw_lo;
        n_yaw_hi = r_yaw_hi;
        o_evt.done = 1'b0;
        o_evt.good = (r_sum == i_byte);
        o_evt.yaw  = {r_yaw_hi, r_yaw_lo};
        if (i_en) begin
            if (r_pos < POS_SUM0) begin
                if (i_byte == HDR_BYTE) begin
                    n_pos = r_pos + POS_W'(1);
                end else begin
                    n_pos = '0;
                    n_sum = '0;
                end
            end else if (r_pos < POS_CHECK) begin
                n_sum = (r_pos == POS_SUM0) ? i_byte : r_sum + i_byte;
                if (r_pos == POS_YAW_LO) begin
                    n_yaw_lo = i_byte;
                end
                if (r_pos == POS_YAW_HI) begin
                    n_yaw_hi = i_byte;
                end
                n_pos = r_pos + POS_W'(1);
            end else begin
                o_evt.done = 1'b1;
                n_pos = '0;
                n_sum = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_sum    <= '0;
            r_yaw_lo <= '0;
            r_yaw_hi <= '0;
        end else begin
            r_pos    <= n_pos;
            r_sum    <= n_sum;
            r_yaw_lo <= n_yaw_lo;
            r_yaw_hi <= n_yaw_hi;
        end
    end

`ifndef ASSERT_OFF
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_CHECK)
        else $error("frame position past checksum byte");
`endif

endmodule
`default_nettype wire

@@ rtl/core/imu_unwrap.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Heading unwrap and result register
// Seeds on the first good frame, tracks a saturating revolution count,
// keeps the frame counters and holds the result word until it is taken.
// ----------------------------------------------------------------------------
module imu_unwrap
    import imu_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire t_frame_evt    i_evt,
    input  wire logic          i_out_stall,
    output logic               o_out_valid,
    output logic               o_frame_good,
    output logic signed [31:0] o_heading_centideg,
    output logic signed [15:0] o_yaw_centideg,
    output logic signed [15:0] o_turn_count,
    output logic [31:0]        o_good_frames,
    output logic [31:0]        o_checksum_errors
);

    logic               r_seeded, n_seeded;
    logic signed [15:0] r_last, n_last;
    logic signed [15:0] r_rev, n_rev;
    logic [31:0]        r_good_cnt, n_good_cnt;
    logic [31:0]        r_bad_cnt, n_bad_cnt;
    logic               r_out_valid, n_out_valid;
    logic               r_good;
    logic signed [31:0] r_heading;

    logic signed [15:0] base;
    logic signed [16:0] step;
    logic signed [32:0] turns;
    logic signed [32:0] heading;

    always_comb begin
        n_seeded   = r_seeded;
        n_last     = r_last;
        n_rev      = r_rev;
        n_good_cnt = r_good_cnt;
        n_bad_cnt  = r_bad_cnt;
        base = r_seeded ? r_last : i_evt.yaw;
        step = 17'(i_evt.yaw) - 17'(base);
        if (i_evt.done) begin
            if (i_evt.good) begin
                n_seeded   = 1'b1;
                n_last     = i_evt.yaw;
                n_good_cnt = r_good_cnt + 32'd1;
                if (step > HALF_TURN) begin
                    if (r_rev > REV_MIN) begin
                        n_rev = r_rev - 16'sd1;
                    end
                end else if (step < -HALF_TURN) begin
                    if (r_rev < REV_MAX) begin
                        n_rev = r_rev + 16'sd1;
                    end
                end
            end else begin
                n_bad_cnt = r_bad_cnt + 32'd1;
            end
        end
        turns   = 33'(n_rev) * 33'(FULL_TURN);
        heading = -(turns + 33'(n_last));
        if (i_evt.done) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seeded    <= 1'b0;
            r_last      <= '0;
            r_rev       <= '0;
            r_good_cnt  <= '0;
            r_bad_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_seeded    <= n_seeded;
            r_last      <= n_last;
            r_rev       <= n_rev;
            r_good_cnt  <= n_good_cnt;
            r_bad_cnt   <= n_bad_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // The heading is only loaded with a new frame; counters above already hold
    // the matching values for the other fields.
    always_ff @(posedge i_clk) begin
        if (i_evt.done) begin
            r_good    <= i_evt.good;
            r_heading <= heading[31:0];
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_frame_good       = r_good;
    assign o_heading_centideg = r_heading;
    assign o_yaw_centideg     = r_last;
    assign o_turn_count       = r_rev;
    assign o_good_frames      = r_good_cnt;
    assign o_checksum_errors  = r_bad_cnt;

`ifndef ASSERT_OFF
    a_rev_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rev != -16'sd32768)
        else $error("revolution count left its saturation range");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_out_stall |-> !i_evt.done)
        else $error("new frame overwrote a result still waiting");

    a_one_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_evt.done |=> ($countones({r_good_cnt != $past(r_good_cnt),
                                    r_bad_cnt != $past(r_bad_cnt)}) == 1))
        else $error("frame did not advance exactly one counter");
`endif

endmodule
`default_nettype wire

@@ rtl/core/imu_yaw_frame_parser_unwrap.sv @@
`timescale 1ns / 1ps
`default_nettype none
// A byte is registered in the input register at acceptance and processed from there;
// the result word for a checksum byte is registered in the unwrap stage once that byte is processed.
// Throughput: one byte per cycle. Input stalls only when the checksum byte
// waits in the input register while an earlier result is still held downstream.
// Reset (synchronous, active low) clears the parser position, checksum,
// unwrap state, both frame counters and both valid flags.
// ----------------------------------------------------------------------------
// Yaw frame parser with heading unwrap
// Input register for received bytes, frame collector and unwrap stage.
// ----------------------------------------------------------------------------
module imu_yaw_frame_parser_unwrap
    import imu_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire logic [7:0]    i_rx_byte,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output logic               o_frame_good,
    output logic signed [31:0] o_heading_centideg,
    output logic signed [15:0] o_yaw_centideg,
    output logic signed [15:0] o_turn_count,
    output logic [31:0]        o_good_frames,
    output logic [31:0]        o_checksum_errors
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       at_check;
    logic       consume;
    logic       accept;
    t_frame_evt evt;

    // A checksum word must wait while the previous result is still held.
    assign consume    = r_in_valid && !(at_check && o_out_valid && i_out_stall);
    assign o_in_stall = r_in_valid && !consume;
    assign accept     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (consume) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_byte <= i_rx_byte;
        end
    end

    imu_frame u_frame (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (consume),
        .i_byte     (r_in_byte),
        .o_evt      (evt),
        .o_at_check (at_check)
    );

    imu_unwrap u_unwrap (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_evt              (evt),
        .i_out_stall        (i_out_stall),
        .o_out_valid        (o_out_valid),
        .o_frame_good       (o_frame_good),
        .o_heading_centideg (o_heading_centideg),
        .o_yaw_centideg     (o_yaw_centideg),
        .o_turn_count       (o_turn_count),
        .o_good_frames      (o_good_frames),
        .o_checksum_errors  (o_checksum_errors)
    );

endmodule
`default_nettype wire

@@ tb/sv/imu_yaw_frame_parser_unwrap_chk.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Yaw frame parser scoreboard
// Watches the byte and result channels, tracks frame parsing and heading
// unwrap on its own, and compares every result word field by field.
// ----------------------------------------------------------------------------
module imu_yaw_frame_parser_unwrap_chk
    import imu_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire logic               i_in_stall,
    input  wire logic [7:0]         i_rx_byte,
    input  wire logic               i_out_valid,
    input  wire logic               i_out_stall,
    input  wire logic               i_frame_good,
    input  wire logic signed [31:0] i_heading_centideg,
    input  wire logic signed [15:0] i_yaw_centideg,
    input  wire logic signed [15:0] i_turn_count,
    input  wire logic [31:0]        i_good_frames,
    input  wire logic [31:0]        i_checksum_errors,
    output int                      o_pending,
    output int                      o_errors
);

    typedef struct {
        logic               good;
        logic signed [31:0] heading;
        logic signed [15:0] yaw;
        logic signed [15:0] turns;
        logic [31:0]        goods;
        logic [31:0]        bads;
    } t_frame_result;

    t_frame_result expected_frames[$];

    logic [POS_W-1:0]   byte_pos;
    logic [7:0]         frame_sum;
    logic [7:0]         yaw_lo;
    logic [7:0]         yaw_hi;
    logic               seeded;
    logic signed [15:0] prev_yaw;
    logic signed [15:0] revs;
    logic [31:0]        good_count;
    logic [31:0]        bad_count;
    int                 mismatches = 0;

    task automatic clear_state();
        byte_pos   = '0;
        frame_sum  = '0;
        yaw_lo     = '0;
        yaw_hi     = '0;
        seeded     = 1'b0;
        prev_yaw   = '0;
        revs       = '0;
        good_count = '0;
        bad_count  = '0;
        expected_frames.delete();
    endtask

    task automatic unwrap_yaw();
        logic signed [15:0] yaw_now;
        int                 delta;
        yaw_now = {yaw_hi, yaw_lo};
        // The first good frame only sets the baseline.
        if (!seeded) begin
            prev_yaw = yaw_now;
            seeded   = 1'b1;
        end
        delta = int'(yaw_now) - int'(prev_yaw);
        if (delta > int'(HALF_TURN)) begin
            if (revs > REV_MIN) revs = revs - 16'sd1;
        end else if (delta < -int'(HALF_TURN)) begin
            if (revs < REV_MAX) revs = revs + 16'sd1;
        end
        prev_yaw   = yaw_now;
        good_count = good_count + 32'd1;
    endtask

    task automatic parse_word(input logic [7:0] b);
        t_frame_result r;
        longint        hd;
        if (byte_pos < POS_SUM0) begin
            if (b == HDR_BYTE) begin
                byte_pos = byte_pos + 1'b1;
            end else begin
                byte_pos  = '0;
                frame_sum = '0;
            end
        end else if (byte_pos < POS_CHECK) begin
            frame_sum = (byte_pos == POS_SUM0) ? b : frame_sum + b;
            if (byte_pos == POS_YAW_LO) yaw_lo = b;
            if (byte_pos == POS_YAW_HI) yaw_hi = b;
            byte_pos = byte_pos + 1'b1;
        end else begin
            r.good = (frame_sum == b);
            if (r.good) unwrap_yaw();
            else bad_count = bad_count + 32'd1;
            byte_pos  = '0;
            frame_sum = '0;
            // Heading is clockwise positive, so the unwrapped yaw is negated.
            hd = -(longint'(prev_yaw) + longint'(FULL_TURN) * longint'(revs));
            r.heading = hd[31:0];
            r.yaw     = prev_yaw;
            r.turns   = revs;
            r.goods   = good_count;
            r.bads    = bad_count;
            expected_frames.push_back(r);
        end
    endtask

    task automatic report(input string field, input longint want, input longint got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
            mismatches++;
        end
    endtask

    task automatic check_frame();
        t_frame_result r;
        if (expected_frames.size() == 0) begin
            $display("%0t: result word with no frame pending, heading %0d", $time,
                     i_heading_centideg);
            mismatches++;
        end else begin
            r = expected_frames.pop_front();
            report("frame_good", r.good, i_frame_good);
            report("heading_centideg", r.heading, i_heading_centideg);
            report("yaw_centideg", r.yaw, i_yaw_centideg);
            report("turn_count", r.turns, i_turn_count);
            report("good_frames", r.goods, i_good_frames);
            report("checksum_errors", r.bads, i_checksum_errors);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_state();
        end else begin
            if (i_out_valid && !i_out_stall) check_frame();
            if (i_in_valid && !i_in_stall) parse_word(i_rx_byte);
        end
        o_pending <= expected_frames.size();
        o_errors  <= mismatches;
    end

endmodule

@@ tb/sv/imu_yaw_frame_parser_unwrap_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Yaw frame parser testbench
// Feeds header noise, good and corrupted frames with a yaw random walk that
// crosses the half-turn boundary, under several idle and stall patterns.
// ----------------------------------------------------------------------------
module imu_yaw_frame_parser_unwrap_tb;
    import imu_pkg::*;

    localparam int SEG_WORDS    = 230;
    localparam int NUM_SEGS     = 6;
    localparam int HOLD_SEG     = 4;
    localparam int HOLD_CYCLES  = 300;
    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 10;

    // Sender idle and receiver stall percentages per segment; the last
    // segment picks its own mix frame by frame.
    localparam int IDLE_BY_SEG[NUM_SEGS]  = '{0, 79, 0, 8, 0, 0};
    localparam int STALL_BY_SEG[NUM_SEGS] = '{0, 0, 79, 8, 0, 0};

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic [7:0]         rx_byte   = 8'h00;
    logic               out_stall = 1'b0;
    logic               in_stall;
    logic               out_valid;
    logic               frame_good;
    logic signed [31:0] heading;
    logic signed [15:0] yaw;
    logic signed [15:0] turns;
    logic [31:0]        good_frames;
    logic [31:0]        checksum_errors;
    int                 pending;
    int                 errors;

    int idle_pct     = 0;
    int stall_pct    = 0;
    int sent_words   = 0;
    int yaw_walk     = 0;
    int quiet_cycles = 0;
    bit hold_req     = 1'b0;

    always #5 clk = ~clk;

    imu_yaw_frame_parser_unwrap dut (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_in_valid         (in_valid),
        .o_in_stall         (in_stall),
        .i_rx_byte          (rx_byte),
        .o_out_valid        (out_valid),
        .i_out_stall        (out_stall),
        .o_frame_good       (frame_good),
        .o_heading_centideg (heading),
        .o_yaw_centideg     (yaw),
        .o_turn_count       (turns),
        .o_good_frames      (good_frames),
        .o_checksum_errors  (checksum_errors)
    );

    imu_yaw_frame_parser_unwrap_chk frame_chk (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_in_valid         (in_valid),
        .i_in_stall         (in_stall),
        .i_rx_byte          (rx_byte),
        .i_out_valid        (out_valid),
        .i_out_stall        (out_stall),
        .i_frame_good       (frame_good),
        .i_heading_centideg (heading),
        .i_yaw_centideg     (yaw),
        .i_turn_count       (turns),
        .i_good_frames      (good_frames),
        .i_checksum_errors  (checksum_errors),
        .o_pending          (pending),
        .o_errors           (errors)
    );

    task automatic send_word(input logic [7:0] b);
        while ($urandom_range(0, 99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sent_words++;
    endtask

    // A walk of bounded steps wrapped at the half turn, with the
    // 16-bit extremes, fully random values and steps right at the unwrap
    // threshold mixed in.
    function automatic logic [15:0] next_yaw();
        int y;
        int d;
        d = ($urandom_range(0, 1) != 0) ? int'(HALF_TURN) : -int'(HALF_TURN);
        case ($urandom_range(0, 11))
            0: y = int'($urandom_range(0, 65535)) - 32768;
            1: y = 32767;
            2: y = -32768;
            3, 4: y = yaw_walk + d;
            5, 6: y = yaw_walk + d + ((d > 0) ? 1 : -1);
            default: begin
                y = yaw_walk + int'($urandom_range(0, 18000)) - 9000;
                if (y > int'(HALF_TURN)) y -= int'(FULL_TURN);
                else if (y < -int'(HALF_TURN)) y += int'(FULL_TURN);
            end
        endcase
        if (y > 32767 || y < -32768) y = 2 * yaw_walk - y;
        yaw_walk = y;
        return y[15:0];
    endfunction

    task automatic send_frame(input bit corrupt);
        logic [15:0] yv;
        logic [7:0]  b;
        logic [7:0]  sum;
        yv  = next_yaw();
        sum = '0;
        send_word(HDR_BYTE);
        send_word(HDR_BYTE);
        for (int p = POS_SUM0; p < POS_CHECK; p++) begin
            b = 8'($urandom);
            if (p == POS_SUM0 && $urandom_range(0, 3) == 0) b = HDR_BYTE;
            if (p == POS_YAW_LO) b = yv[7:0];
            if (p == POS_YAW_HI) b = yv[15:8];
            sum += b;
            send_word(b);
        end
        send_word(corrupt ? sum + 8'($urandom_range(1, 255)) : sum);
    endtask

    // Short bursts of header-like junk, usually closed by a non-header byte
    // so that the next frame starts aligned.
    task automatic send_noise();
        int         n;
        logic [7:0] b;
        n = $urandom_range(1, 4);
        repeat (n) send_word(($urandom_range(0, 2) == 0) ? HDR_BYTE : 8'($urandom));
        if ($urandom_range(0, 3) != 0) begin
            b = 8'($urandom);
            if (b == HDR_BYTE) b = 8'h00;
            send_word(b);
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    initial begin
        forever begin
            @(posedge clk);
            if (hold_req) begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end else begin
                out_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int pick;
        int base;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Broken header, then a corrupted frame while nothing is seeded yet.
        send_word(8'hFF);
        send_word(HDR_BYTE);
        send_word(8'h00);
        send_frame(1'b1);
        wait_drained();

        base = sent_words;
        for (int seg = 0; seg < NUM_SEGS; seg++) begin
            idle_pct  = IDLE_BY_SEG[seg];
            stall_pct = STALL_BY_SEG[seg];
            // The long output hold lets the sender run into the input stall.
            if (seg == HOLD_SEG) hold_req = 1'b1;
            while (sent_words < base + (seg + 1) * SEG_WORDS) begin
                if (seg == NUM_SEGS - 1) begin
                    idle_pct  = $urandom_range(0, 79);
                    stall_pct = $urandom_range(0, 79);
                end
                pick = $urandom_range(0, 19);
                if (pick < 2) send_noise();
                else send_frame(pick < 5);
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
